// File: src/button_click_classifier_unit_assert.svh
// Assertion macros for the button click classifier.
// Used by button_click_classifier_unit; expects a clock named clk and a reset named rst.
`ifndef BUTTON_CLICK_CLASSIFIER_UNIT_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("button click classifier check failed");

// The consequent must hold in the cycle after the antecedent.
`define BCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("button click classifier check failed");

`endif

// File: src/btncc_pkg.sv
// Package for the button click classifier: widths, event codes, register indexes
// and reset values. Depends on nothing.
package btncc_pkg;

  localparam int CNT_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS = 2'd0,
    REG_GAP_MIN    = 2'd1,
    REG_GAP_MAX    = 2'd2,
    REG_UNUSED     = 2'd3
  } cfg_idx_t;

  localparam cnt_t LONG_PRESS_RST = 16'd500;
  localparam cnt_t GAP_MIN_RST = 16'd50;
  localparam cnt_t GAP_MAX_RST = 16'd300;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == CNT_MAX) ? v : v + cnt_t'(1);
  endfunction

endpackage

// File: src/button_click_classifier_unit.sv
// Top level of the button click classifier: input register, classification logic
// and result register. Depends on btncc_pkg and button_click_classifier_unit_assert.svh.
//
// Usage: each transfer on the input channel is one periodic tick carrying the
// sampled active-low button level on key_level. Every tick yields exactly one
// transfer on the output channel with click_event set to none, single, double
// or long click. The three tick-count limits are written through the cfg port;
// the user writes them only while no tick is in flight; the block does not check.
// The result passes from the input register into the result register before it
// is offered, and a stall can hold it in either. A new tick is accepted in every
// cycle while in_stall is low; each tick takes a single pass of the counter and
// compare logic between the two registers.
// Reset clears the counters, the pending flags and the valid flags of both pipeline
// registers and loads the limits with 500, 50 and 300 ticks.
// When the receiver stalls, the result register holds its value and the input
// register holds one further tick; in_stall rises once both are full.
`include "button_click_classifier_unit_assert.svh"

module button_click_classifier_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        key_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  click_event,
  input  logic        cfg_write,
  input  logic [btncc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [btncc_pkg::CNT_W-1:0] cfg_data
);

  btncc_pkg::cnt_t long_press_ticks;
  btncc_pkg::cnt_t gap_min_ticks;
  btncc_pkg::cnt_t gap_max_ticks;

  btncc_pkg::cnt_t released_ticks;
  btncc_pkg::cnt_t held_ticks;
  logic            was_pressed;
  logic            event_done;

  btncc_pkg::cnt_t released_ticks_next;
  btncc_pkg::cnt_t held_ticks_next;
  logic            was_pressed_next;
  logic            event_done_next;
  btncc_pkg::event_t result_next;

  logic              in_full;
  logic              in_key;
  logic              res_valid;
  btncc_pkg::event_t res_event;

  logic advance;
  logic fire;
  logic in_take;

  assign advance = !res_valid || !out_stall;
  assign fire = in_full && advance;
  assign in_stall = in_full && !advance;
  assign in_take = in_valid && !in_stall;

  assign out_valid = res_valid;
  assign click_event = res_event;

  always_comb begin
    logic released;
    logic pressed;
    released = in_key;
    pressed = !in_key;
    released_ticks_next = released_ticks;
    held_ticks_next = held_ticks;
    was_pressed_next = was_pressed;
    event_done_next = event_done;
    result_next = btncc_pkg::EV_NONE;

    if (event_done) begin
      was_pressed_next = 1'b0;
      released_ticks_next = '0;
      held_ticks_next = '0;
      if (released) begin
        event_done_next = 1'b0;
      end
    end

    if (pressed && !event_done_next) begin
      was_pressed_next = 1'b1;
      held_ticks_next = btncc_pkg::sat_inc(held_ticks_next);
    end

    if (held_ticks_next > long_press_ticks) begin
      event_done_next = 1'b1;
      result_next = btncc_pkg::EV_LONG;
    end else begin
      if (was_pressed_next && released) begin
        released_ticks_next = btncc_pkg::sat_inc(released_ticks_next);
      end
      if (was_pressed_next && released_ticks_next > gap_min_ticks &&
          released_ticks_next < gap_max_ticks) begin
        if (pressed) begin
          event_done_next = 1'b1;
          result_next = btncc_pkg::EV_DOUBLE;
        end
      end else if (was_pressed_next && released_ticks_next > gap_max_ticks) begin
        event_done_next = 1'b1;
        result_next = btncc_pkg::EV_SINGLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= btncc_pkg::LONG_PRESS_RST;
      gap_min_ticks <= btncc_pkg::GAP_MIN_RST;
      gap_max_ticks <= btncc_pkg::GAP_MAX_RST;
    end else if (cfg_write) begin
      unique case (btncc_pkg::cfg_idx_t'(cfg_index))
        btncc_pkg::REG_LONG_PRESS: long_press_ticks <= cfg_data;
        btncc_pkg::REG_GAP_MIN:    gap_min_ticks <= cfg_data;
        btncc_pkg::REG_GAP_MAX:    gap_max_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      res_valid <= 1'b0;
      released_ticks <= '0;
      held_ticks <= '0;
      was_pressed <= 1'b0;
      event_done <= 1'b0;
    end else begin
      if (in_take) begin
        in_full <= 1'b1;
      end else if (fire) begin
        in_full <= 1'b0;
      end
      if (fire) begin
        res_valid <= 1'b1;
        released_ticks <= released_ticks_next;
        held_ticks <= held_ticks_next;
        was_pressed <= was_pressed_next;
        event_done <= event_done_next;
      end else if (!out_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_key <= key_level;
    end
    if (fire) begin
      res_event <= result_next;
    end
  end

  `BCC_ASSERT_SAME(a_idle_no_gap, !was_pressed, released_ticks == '0)
  `BCC_ASSERT_SAME(a_event_reported, $rose(event_done),
                   res_valid && res_event != btncc_pkg::EV_NONE)
  `BCC_ASSERT_NEXT(a_stall_needs_full, in_stall, in_full)

endmodule
